[hw/rtl/bdrd_pkg.sv]
// Shared types, constants and calendar tables for the business day return date core.
`default_nettype none

package bdrd_pkg;

  localparam int COUNT_BITS_DEF = 12;

  localparam logic [13:0] MAX_YEAR = 14'd9999;
  localparam logic [2:0]  WD_FRIDAY = 3'd5;
  localparam logic [2:0]  WD_SATURDAY = 3'd6;

  localparam int          MUL_A_BITS = 15;
  localparam int          MUL_K_BITS = 17;
  localparam int          PROD_BITS = MUL_A_BITS + MUL_K_BITS;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [16:0] K_DIV100 = 17'd5243;
  localparam logic [16:0] K_DIV7 = 17'd74899;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [11:0] business_days;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  return_dom;
    logic [3:0]  return_month;
    logic [13:0] return_year;
    logic [2:0]  return_weekday;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVY,
    S_SPLIT,
    S_CHECK,
    S_DIV7,
    S_WDAY,
    S_WALK,
    S_DONE
  } state_t;

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula, with January and February taken as
  // months 11 and 12 of the previous year.
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] ofs;
    case (m)
      4'd1:  ofs = 5'd28;
      4'd2:  ofs = 5'd31;
      4'd3:  ofs = 5'd2;
      4'd4:  ofs = 5'd5;
      4'd5:  ofs = 5'd7;
      4'd6:  ofs = 5'd10;
      4'd7:  ofs = 5'd12;
      4'd8:  ofs = 5'd15;
      4'd9:  ofs = 5'd18;
      4'd10: ofs = 5'd20;
      4'd11: ofs = 5'd23;
      4'd12: ofs = 5'd25;
      default: ofs = 5'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/business_day_return_date_core.sv]
// Top level: walks a calendar date forward by a count of business days.
//
//   channel | signals                       | payload     | direction
//   --------+-------------------------------+-------------+----------
//   in      | in_valid, in_stall, in_item   | in_item_t   | into core
//   out     | out_valid, out_stall, out_item| out_item_t  | out of core
//
// After a transfer an item passes through setup (split of the year by 100,
// date check, weekday by division by 7; an invalid date skips to S_DONE),
// then walks forward one calendar day at a time, and S_DONE loads the output
// register. The walk sets the run time; a shared constant multiplier does
// the divisions by 100 and 7.
// Reset is synchronous and clears the sequencer and the output valid.
// The output register lets a new transfer in while a result waits under stall.
`default_nettype none

module business_day_return_date_core
  import bdrd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  state_t                  state;
  state_t                  state_next;
  logic [4:0]              day;
  logic [3:0]              month;
  logic [13:0]             year;
  logic [COUNT_BITS-1:0]   cnt;
  logic [2:0]              wd;
  logic [6:0]              r100;
  logic [1:0]              q4;
  logic [6:0]              qy;
  logic [MUL_A_BITS-1:0]   sum;
  status_t                 status;
  logic [PROD_BITS-1:0]    prod;

  logic [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_K_BITS-1:0]   mul_k;
  logic [12:0]             quot;
  logic                    leap;
  logic [4:0]              mdays;
  logic                    date_ok;
  logic                    early;
  logic [13:0]             yy;
  logic [6:0]              qyy;
  logic [MUL_A_BITS-1:0]   wsum;
  logic                    weekend;
  logic                    load_out;

  assign quot    = prod[RECIP_SHIFT +: 13];
  assign leap    = ((r100[1:0] == 2'd0) && (r100 != 7'd0)) || ((r100 == 7'd0) && (q4 == 2'd0));
  assign mdays   = month_length(month, leap);
  assign date_ok = (year != 14'd0) && (year <= MAX_YEAR) && (month >= 4'd1) &&
                   (month <= 4'd12) && (day != 5'd0) && (day <= mdays);
  assign early   = (month <= 4'd2);
  assign yy      = year - {13'd0, early};
  assign qyy     = (early && (r100 == 7'd0)) ? qy - 7'd1 : qy;
  assign wsum    = MUL_A_BITS'(day) + MUL_A_BITS'(yy) + MUL_A_BITS'(yy >> 2) -
                   MUL_A_BITS'(qyy) + MUL_A_BITS'(qyy >> 2) +
                   MUL_A_BITS'(month_offset(month));
  assign weekend = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mul_a      = MUL_A_BITS'(year);
    mul_k      = K_DIV100;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = date_ok ? S_DIV7 : S_DONE;
      end
      S_DIV7: begin
        mul_a      = sum;
        mul_k      = K_DIV7;
        state_next = S_WDAY;
      end
      S_WDAY: begin
        state_next = (cnt == '0) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (!weekend && (cnt == '0)) begin
          state_next = S_DONE;
        end else if ((day >= mdays) && (month == 4'd12) && (year >= MAX_YEAR)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(mul_a) * PROD_BITS'(mul_k);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          day    <= in_item.start_day;
          month  <= in_item.start_month;
          year   <= in_item.start_year;
          cnt    <= COUNT_BITS'(in_item.business_days);
          status <= STATUS_OK;
        end
      end
      S_SPLIT: begin
        qy   <= quot[6:0];
        q4   <= quot[1:0];
        r100 <= 7'(year - 14'(quot[6:0]) * 14'd100);
      end
      S_CHECK: begin
        if (date_ok) begin
          sum <= wsum;
        end else begin
          status <= STATUS_BAD_DATE;
          day    <= 5'd0;
          month  <= 4'd0;
          year   <= 14'd0;
          wd     <= 3'd0;
        end
      end
      S_WDAY: begin
        wd <= 3'(sum - MUL_A_BITS'(quot) * MUL_A_BITS'(7));
      end
      S_WALK: begin
        if (weekend || (cnt != '0)) begin
          if (!weekend) begin
            cnt <= cnt - COUNT_BITS'(1);
          end
          if ((day >= mdays) && (month == 4'd12) && (year >= MAX_YEAR)) begin
            status <= STATUS_OVERFLOW;
            wd     <= WD_FRIDAY;
          end else begin
            wd <= (wd == WD_SATURDAY) ? 3'd0 : wd + 3'd1;
            if (day >= mdays) begin
              day <= 5'd1;
              if (month == 4'd12) begin
                month <= 4'd1;
                year  <= year + 14'd1;
                if (r100 == 7'd99) begin
                  r100 <= 7'd0;
                  q4   <= q4 + 2'd1;
                end else begin
                  r100 <= r100 + 7'd1;
                end
              end else begin
                month <= month + 4'd1;
              end
            end else begin
              day <= day + 5'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.return_dom     <= day;
      out_item.return_month   <= month;
      out_item.return_year    <= year;
      out_item.return_weekday <= wd;
      out_item.status         <= status;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bdrd_checker.sv]
// Port-level checker for the business day return date core, bound to the top level.
`default_nettype none

module bdrd_checker
  import bdrd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // The core works on one date at a time, so it stalls right after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed or dropped");

  a_bad_date_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == STATUS_BAD_DATE)) |->
    ((out_item.return_dom == 5'd0) && (out_item.return_month == 4'd0) &&
     (out_item.return_year == 14'd0) && (out_item.return_weekday == 3'd0)))
    else $error("invalid date result is not all zero");

  a_overflow_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == STATUS_OVERFLOW)) |->
    ((out_item.return_dom == 5'd31) && (out_item.return_month == 4'd12) &&
     (out_item.return_year == MAX_YEAR) && (out_item.return_weekday == WD_FRIDAY)))
    else $error("overflow result is not the last representable date");

endmodule

bind business_day_return_date_core bdrd_checker u_bdrd_checker (.*);

`default_nettype wire

[tb/bdrd_return_date_monitor.sv]
// Monitor that predicts each return date from the input transfers and checks the results.
module bdrd_return_date_monitor
  import bdrd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        errors,
  output int        pending,
  output int        dates_in,
  output int        bad_dates,
  output int        overflows
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t expected_dates[$];
  int        fail_total;
  int        in_total;
  int        bad_total;
  int        overflow_total;

  function automatic bit leap_year(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int days_per_month(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int day_of_week(input int y, input int m, input int d);
    int a;
    int yy;
    int mm;
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic bit rest_day(input int wd);
    return wd == int'(WD_FRIDAY) || wd == int'(WD_SATURDAY);
  endfunction

  function automatic bit step_day(inout int y, inout int m, inout int d, inout int wd);
    int nd;
    int nm;
    int ny;
    nd = d + 1;
    nm = m;
    ny = y;
    if (nd > days_per_month(ny, nm)) begin
      nd = 1;
      nm++;
      if (nm > 12) begin
        nm = 1;
        if (ny >= int'(MAX_YEAR)) return 1'b0;
        ny++;
      end
    end
    d  = nd;
    m  = nm;
    y  = ny;
    wd = (wd + 1) % 7;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_return(input in_item_t it);
    out_item_t r;
    int        d;
    int        m;
    int        y;
    int        n;
    int        wd;
    int        cnt;
    status_t   st;
    d  = it.start_day;
    m  = it.start_month;
    y  = it.start_year;
    n  = it.business_days & ((1 << COUNT_BITS) - 1);
    r  = '0;
    st = STATUS_OK;
    if (y < 1 || y > int'(MAX_YEAR) || m < 1 || m > 12 || d < 1 ||
        d > days_per_month(y, m)) begin
      r.status = STATUS_BAD_DATE;
      return r;
    end
    wd  = day_of_week(y, m, d);
    cnt = 0;
    while (cnt < n && st == STATUS_OK) begin
      if (!rest_day(wd)) begin
        cnt++;
        if (!step_day(y, m, d, wd)) st = STATUS_OVERFLOW;
      end
      while (st == STATUS_OK && rest_day(wd)) begin
        if (!step_day(y, m, d, wd)) st = STATUS_OVERFLOW;
      end
    end
    if (st == STATUS_OVERFLOW) begin
      y  = MAX_YEAR;
      m  = 12;
      d  = 31;
      wd = day_of_week(y, m, d);
    end
    r.return_dom     = d[4:0];
    r.return_month   = m[3:0];
    r.return_year    = y[13:0];
    r.return_weekday = wd[2:0];
    r.status         = st;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("result transfer with no return date expected: %p", out_item);
          fail_total++;
        end else begin
          want = expected_dates.pop_front();
          if (out_item.return_dom !== want.return_dom) begin
            $error("return_dom: expected %0d, actual %0d", want.return_dom,
                   out_item.return_dom);
            fail_total++;
          end
          if (out_item.return_month !== want.return_month) begin
            $error("return_month: expected %0d, actual %0d", want.return_month,
                   out_item.return_month);
            fail_total++;
          end
          if (out_item.return_year !== want.return_year) begin
            $error("return_year: expected %0d, actual %0d", want.return_year,
                   out_item.return_year);
            fail_total++;
          end
          if (out_item.return_weekday !== want.return_weekday) begin
            $error("return_weekday: expected %0d, actual %0d", want.return_weekday,
                   out_item.return_weekday);
            fail_total++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_return(in_item);
        expected_dates.push_back(want);
        in_total++;
        if (want.status == STATUS_BAD_DATE) bad_total++;
        if (want.status == STATUS_OVERFLOW) overflow_total++;
      end
    end
    errors    <= fail_total;
    pending   <= expected_dates.size();
    dates_in  <= in_total;
    bad_dates <= bad_total;
    overflows <= overflow_total;
  end

endmodule

[tb/business_day_return_date_core_test.sv]
// Testbench top: clock, reset, date stimulus, output stalls and the final verdict.
module business_day_return_date_core_test
  import bdrd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_DATES = 80;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 3000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic      steady;
  logic      hold_request;

  int        errors;
  int        pending;
  int        dates_in;
  int        bad_dates;
  int        overflows;

  business_day_return_date_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  bdrd_return_date_monitor monitor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending),
    .dates_in  (dates_in),
    .bad_dates (bad_dates),
    .overflows (overflows)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t date_item(input int d, input int m, input int y, input int n);
    in_item_t it;
    it.start_day     = d[4:0];
    it.start_month   = m[3:0];
    it.start_year    = y[13:0];
    it.business_days = n[11:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       kind;
    int       m;
    int       y;
    int       n;
    int       dmax;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      it.start_day     = 5'($urandom_range(0, 31));
      it.start_month   = 4'($urandom_range(0, 15));
      it.start_year    = 14'($urandom_range(0, 16383));
      it.business_days = 12'($urandom_range(0, 4095));
      return it;
    end
    y    = (kind >= 92) ? $urandom_range(9985, 9999) : $urandom_range(1, 9999);
    m    = $urandom_range(1, 12);
    dmax = (m == 2) ? 29 : (m inside {4, 6, 9, 11}) ? 30 : 31;
    n    = (kind >= 80) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
    return date_item($urandom_range(1, dmax), m, y, n);
  endfunction

  task automatic offer(input in_item_t item);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 33);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer(date_item(1, 1, 1, 0));
    offer(date_item(1, 1, 1, 1));
    offer(date_item(31, 12, 9999, 0));
    offer(date_item(31, 12, 9999, 1));
    offer(date_item(20, 12, 9999, 4095));
    offer(date_item(7, 6, 2024, 0));
    offer(date_item(8, 6, 2024, 1));
    offer(date_item(29, 2, 2000, 10));
    offer(date_item(29, 2, 1900, 3));
    offer(date_item(29, 2, 2024, 5));
    offer(date_item(29, 2, 2023, 5));
    offer(date_item(31, 4, 2024, 1));
    offer(date_item(0, 5, 2024, 1));
    offer(date_item(31, 0, 2024, 1));
    offer(date_item(1, 13, 2024, 1));
    offer(date_item(31, 15, 16383, 4095));
    offer(date_item(1, 1, 0, 5));
    offer(date_item(1, 1, 10000, 5));
    offer(date_item(28, 2, 2100, 2));
    offer(date_item(31, 12, 1999, 4095));
    offer(date_item(30, 11, 2023, 3));

    for (int i = 0; i < RANDOM_DATES; i++) begin
      steady <= (i >= 50 && i < 80);
      if (i == 20) hold_request <= 1'b1;
      offer(random_item());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d start dates, %0d of them invalid and %0d running past year 9999,",
             dates_in, bad_dates, overflows);
    $display("under random stalls on both sides and one long output hold-off.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[business_day_return_date_core.f]
hw/rtl/bdrd_pkg.sv
hw/rtl/business_day_return_date_core.sv
hw/rtl/bdrd_checker.sv
tb/bdrd_return_date_monitor.sv
tb/business_day_return_date_core_test.sv
